[rtl/tlbfl_pkg.sv]
package tlbfl_pkg;

    // buffer geometry
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W  = IDX_W;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // item field widths
    localparam int PID_W   = 16;
    localparam int PAGE_W  = 20;
    localparam int FRAME_W = 20;
    localparam int CFG_W   = 5;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [RANK_W-1:0] rank_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    // operation codes
    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_INSERT = 1'b1;

    // register indexes
    localparam logic REG_ENTRIES_IN_USE = 1'b0;
    localparam logic REG_REPLACE_LRU    = 1'b1;

    localparam logic [CFG_W-1:0] ENTRIES_IN_USE_RESET = 5'd16;

    typedef struct packed {
        logic               mode;
        logic [PID_W-1:0]   process_id;
        logic [PAGE_W-1:0]  page_number;
        logic [FRAME_W-1:0] frame_in;
    } cmd_t;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame_out;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LOOK_END,
        ST_INS_END
    } state_t;

    typedef enum logic [1:0] {
        SCAN_MATCH,
        SCAN_FREE,
        SCAN_VICTIM
    } scan_kind_t;

    // update request to the rank file
    typedef struct packed {
        logic  set_valid;
        logic  write_load;
        logic  write_use;
        logic  close_load;
        logic  close_use;
        idx_t  slot;
        rank_t new_rank;
        rank_t gap_load;
        rank_t gap_use;
    } rank_op_t;

endpackage

[rtl/tlbfl_rank_file.sv]
module tlbfl_rank_file (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tlbfl_pkg::rank_op_t           op,
    input  tlbfl_pkg::idx_t               rd_idx,
    output logic [tlbfl_pkg::ENTRIES-1:0] valid,
    output tlbfl_pkg::rank_t              rd_load,
    output tlbfl_pkg::rank_t              rd_use
);
    import tlbfl_pkg::*;

    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    rank_t              load_rank_reg  [ENTRIES];
    rank_t              load_rank_next [ENTRIES];
    rank_t              use_rank_reg   [ENTRIES];
    rank_t              use_rank_next  [ENTRIES];

    // per-entry update: write the chosen slot, close the gap elsewhere
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            valid_next[i]     = valid_reg[i];
            load_rank_next[i] = load_rank_reg[i];
            use_rank_next[i]  = use_rank_reg[i];
            if (op.set_valid && (idx_t'(i) == op.slot))
            begin
                valid_next[i] = 1'b1;
            end
            if (op.write_load && (idx_t'(i) == op.slot))
            begin
                load_rank_next[i] = op.new_rank;
            end
            else if (op.close_load && valid_reg[i] && (load_rank_reg[i] > op.gap_load))
            begin
                load_rank_next[i] = load_rank_reg[i] - rank_t'(1);
            end
            if (op.write_use && (idx_t'(i) == op.slot))
            begin
                use_rank_next[i] = op.new_rank;
            end
            else if (op.close_use && valid_reg[i] && (use_rank_reg[i] > op.gap_use))
            begin
                use_rank_next[i] = use_rank_reg[i] - rank_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            load_rank_reg[i] <= load_rank_next[i];
            use_rank_reg[i]  <= use_rank_next[i];
        end
    end

    assign valid   = valid_reg;
    assign rd_load = load_rank_reg[rd_idx];
    assign rd_use  = use_rank_reg[rd_idx];

endmodule

[rtl/tlb_fifo_lru_lookup_fill.sv]
// channel   | ports                          | handshake
// ----------+--------------------------------+--------------------------------------
// command   | start, busy, cmd               | item taken when start & !busy
// result    | done, result                   | one-cycle strobe, cannot be held off
// config    | wr_en, wr_index, wr_data       | register written when wr_en is high
//
// an item is taken from idle, then a single compare unit walks the buffer entry by entry,
// then an end step updates the ranks, and for an insert also the keys
// a lookup result shows on the cycle after that, while the next item may already start
// an insert with entries_in_use at zero is dropped in the cycle it is taken
// reset clears the valid bits and fill count at once, no clearing pass
// the receiver cannot stall, so there is no output back-pressure to handle
module tlb_fifo_lru_lookup_fill (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  tlbfl_pkg::cmd_t                 cmd,
    output logic                            done,
    output tlbfl_pkg::result_t              result,
    input  logic                            wr_en,
    input  logic                            wr_index,
    input  logic [tlbfl_pkg::CFG_W-1:0]     wr_data
);
    import tlbfl_pkg::*;

    // configuration
    logic [CFG_W-1:0]   entries_in_use_reg;
    logic               replace_lru_reg;

    // sequencer and control
    state_t             state_reg;
    state_t             state_next;
    scan_kind_t         kind_reg;
    idx_t               scan_idx_reg;
    logic               found_reg;
    cnt_t               fill_count_reg;
    logic               done_reg;

    // payload
    cmd_t               cmd_reg;
    idx_t               best_idx_reg;
    rank_t              best_load_reg;
    rank_t              best_use_reg;
    result_t            result_reg;
    logic [PID_W-1:0]   entry_pid_reg   [ENTRIES];
    logic [PAGE_W-1:0]  entry_page_reg  [ENTRIES];
    logic [FRAME_W-1:0] entry_frame_reg [ENTRIES];

    // rank file interface
    rank_op_t           rank_op;
    logic [ENTRIES-1:0] valid;
    rank_t              rd_load;
    rank_t              rd_use;

    logic               accept;
    logic               last;
    cnt_t               limit;
    cnt_t               fill_minus1;
    logic               key_eq;
    rank_t              rank_sel;
    rank_t              best_sel;
    logic               rank_less;
    logic               take;

    tlbfl_rank_file u_rank_file (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (rank_op),
        .rd_idx  (scan_idx_reg),
        .valid   (valid),
        .rd_load (rd_load),
        .rd_use  (rd_use)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign last   = (scan_idx_reg == idx_t'(ENTRIES - 1));
    assign done   = done_reg;
    assign result = result_reg;

    // usable entry count, clamped to the buffer size
    always_comb
    begin
        if (int'(entries_in_use_reg) < ENTRIES)
        begin
            limit = cnt_t'(entries_in_use_reg);
        end
        else
        begin
            limit = cnt_t'(ENTRIES);
        end
    end

    assign fill_minus1 = fill_count_reg - cnt_t'(1);

    // shared compare unit: key match plus rank compare against the best so far
    // lookups rank by load order so duplicate keys resolve to the oldest load
    assign key_eq = valid[scan_idx_reg]
                 && (entry_pid_reg[scan_idx_reg] == cmd_reg.process_id)
                 && (entry_page_reg[scan_idx_reg] == cmd_reg.page_number);
    assign rank_sel  = ((kind_reg == SCAN_MATCH) || !replace_lru_reg) ? rd_load : rd_use;
    assign best_sel  = ((kind_reg == SCAN_MATCH) || !replace_lru_reg) ? best_load_reg
                                                                       : best_use_reg;
    assign rank_less = !found_reg || (rank_sel < best_sel);

    always_comb
    begin
        case (kind_reg)
            SCAN_MATCH:  take = key_eq && rank_less;
            SCAN_VICTIM: take = valid[scan_idx_reg] && rank_less;
            SCAN_FREE:   take = !valid[scan_idx_reg] && !found_reg;
            default:     take = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && ((cmd.mode == MODE_LOOKUP) || (limit != '0)))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last)
                begin
                    state_next = (kind_reg == SCAN_MATCH) ? ST_LOOK_END : ST_INS_END;
                end
            end
            ST_LOOK_END: state_next = ST_IDLE;
            ST_INS_END:  state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // rank file requests at the end of an item
    always_comb
    begin
        rank_op          = '0;
        rank_op.slot     = best_idx_reg;
        rank_op.gap_load = best_load_reg;
        rank_op.gap_use  = best_use_reg;
        rank_op.new_rank = fill_minus1[RANK_W-1:0];
        case (state_reg)
            ST_LOOK_END:
            begin
                // hit becomes most recently used
                rank_op.close_use = found_reg;
                rank_op.write_use = found_reg;
            end
            ST_INS_END:
            begin
                rank_op.set_valid  = found_reg;
                rank_op.write_load = found_reg;
                rank_op.write_use  = found_reg;
                if (kind_reg == SCAN_VICTIM)
                begin
                    rank_op.close_load = 1'b1;
                    rank_op.close_use  = 1'b1;
                end
                else
                begin
                    // fresh slot takes the rank just past the current fill
                    rank_op.new_rank = fill_count_reg[RANK_W-1:0];
                end
            end
            default:
            begin
                rank_op.set_valid = 1'b0;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_in_use_reg <= ENTRIES_IN_USE_RESET;
            replace_lru_reg    <= 1'b0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_ENTRIES_IN_USE: entries_in_use_reg <= wr_data;
                REG_REPLACE_LRU:    replace_lru_reg    <= wr_data[0];
                default:            replace_lru_reg    <= replace_lru_reg;
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            kind_reg       <= SCAN_MATCH;
            scan_idx_reg   <= '0;
            found_reg      <= 1'b0;
            fill_count_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_LOOK_END);
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        scan_idx_reg <= '0;
                        found_reg    <= 1'b0;
                        if (cmd.mode == MODE_LOOKUP)
                        begin
                            kind_reg <= SCAN_MATCH;
                        end
                        else if (fill_count_reg < limit)
                        begin
                            kind_reg <= SCAN_FREE;
                        end
                        else
                        begin
                            kind_reg <= SCAN_VICTIM;
                        end
                    end
                end
                ST_SCAN:
                begin
                    scan_idx_reg <= scan_idx_reg + idx_t'(1);
                    if (take)
                    begin
                        found_reg <= 1'b1;
                    end
                end
                ST_INS_END:
                begin
                    if ((kind_reg == SCAN_FREE) && found_reg)
                    begin
                        fill_count_reg <= fill_count_reg + cnt_t'(1);
                    end
                end
                default:
                begin
                    found_reg <= found_reg;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        if ((state_reg == ST_SCAN) && take)
        begin
            best_idx_reg  <= scan_idx_reg;
            best_load_reg <= rd_load;
            best_use_reg  <= rd_use;
        end
        if (state_reg == ST_LOOK_END)
        begin
            result_reg.hit       <= found_reg;
            result_reg.frame_out <= found_reg ? entry_frame_reg[best_idx_reg] : '0;
        end
        if ((state_reg == ST_INS_END) && found_reg)
        begin
            entry_pid_reg[best_idx_reg]   <= cmd_reg.process_id;
            entry_page_reg[best_idx_reg]  <= cmd_reg.page_number;
            entry_frame_reg[best_idx_reg] <= cmd_reg.frame_in;
        end
    end

    // the fill count tracks the number of valid entries
    a_fill_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid) == int'(fill_count_reg))
        else $error("fill count differs from valid entry count");

    // the buffer never fills past its size
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(fill_count_reg) <= ENTRIES)
        else $error("fill count above buffer size");

    // a result only follows the end of a lookup, and the block is free by then
    a_done_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == ST_LOOK_END) && !busy)
        else $error("result strobe without a finished lookup");

    // a miss carries frame zero
    a_miss_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.hit) |-> (result.frame_out == '0))
        else $error("miss with nonzero frame");

    // an insert completion never leaves the fill count above the usable limit by growth
    a_fill_grows_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INS_END && kind_reg == SCAN_FREE) |-> (fill_count_reg < limit))
        else $error("fresh fill at or above the usable entry count");

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;
    import tlbfl_pkg::*;

    // cycles of silence before the run is declared hung
    localparam int WATCHDOG_LIMIT = 1000;
    // cycles an item may still be in flight after the last lookup result
    localparam int DRAIN_CYCLES = ENTRIES + 8;
    // idling: chance in a hundred that the sender pauses before an item
    localparam int IDLE_PERCENT = 37;
    // longest pause, counted from the cycle the block is free again
    localparam int IDLE_MAX = 54;

    typedef enum logic { ROW_ITEM, ROW_CONFIG } row_kind_t;

    // one line of the directed script: an item, or a setting of both registers
    typedef struct {
        row_kind_t  kind;
        cmd_t       c;
        bit         typed;
        result_t    want;
        logic [4:0] n;
        logic       lru;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    cmd_t               cmd;
    logic               done;
    result_t            result;
    logic               wr_en;
    logic               wr_index;
    logic [CFG_W-1:0]   wr_data;

    // typed-in expectation travels beside the item it belongs to
    bit                 row_typed;
    result_t            row_want;

    // shadow copy of the buffer
    logic               tlb_valid [ENTRIES];
    logic [PID_W-1:0]   tlb_pid   [ENTRIES];
    logic [PAGE_W-1:0]  tlb_page  [ENTRIES];
    logic [FRAME_W-1:0] tlb_frame [ENTRIES];
    rank_t              tlb_load  [ENTRIES];
    rank_t              tlb_use   [ENTRIES];
    cnt_t               tlb_fill;
    logic [CFG_W-1:0]   cfg_entries;
    logic               cfg_lru;

    result_t            pending_lookups [$];
    logic [PID_W+PAGE_W-1:0] key_pool [$];
    int                 error_count;
    int                 quiet_cycles;
    bit                 idle_on;

    tlb_fifo_lru_lookup_fill uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .done     (done),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always #1 clk = ~clk;

    // shadow state as it is right after reset
    task automatic tlb_clear();
        for (int i = 0; i < ENTRIES; i++)
        begin
            tlb_valid[i] = 1'b0;
            tlb_pid[i]   = '0;
            tlb_page[i]  = '0;
            tlb_frame[i] = '0;
            tlb_load[i]  = '0;
            tlb_use[i]   = '0;
        end
        tlb_fill    = '0;
        cfg_entries = ENTRIES_IN_USE_RESET;
        cfg_lru     = 1'b0;
    endtask

    // walk one item through the shadow buffer; a lookup yields a result
    task automatic tlb_predict(input cmd_t c, output bit yields, output result_t r);
        int    best;
        int    slot;
        int    lim;
        bit    found;
        rank_t gap_load;
        rank_t gap_use;
        yields = 1'b0;
        r      = '0;
        if (c.mode == MODE_LOOKUP)
        begin
            yields = 1'b1;
            found  = 1'b0;
            best   = 0;
            // with duplicate keys the oldest load wins
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (tlb_valid[i] && tlb_pid[i] == c.process_id &&
                    tlb_page[i] == c.page_number &&
                    (!found || tlb_load[i] < tlb_load[best]))
                begin
                    best  = i;
                    found = 1'b1;
                end
            end
            if (found)
            begin
                gap_use = tlb_use[best];
                for (int i = 0; i < ENTRIES; i++)
                    if (tlb_valid[i] && tlb_use[i] > gap_use)
                        tlb_use[i] = tlb_use[i] - 1'b1;
                tlb_use[best] = rank_t'(int'(tlb_fill) - 1);
                r.hit       = 1'b1;
                r.frame_out = tlb_frame[best];
            end
        end
        else
        begin
            lim  = (int'(cfg_entries) < ENTRIES) ? int'(cfg_entries) : ENTRIES;
            slot = -1;
            if (lim != 0)
            begin
                if (int'(tlb_fill) < lim)
                begin
                    for (int i = ENTRIES - 1; i >= 0; i--)
                        if (!tlb_valid[i])
                            slot = i;
                    if (slot >= 0)
                        tlb_fill = tlb_fill + 1'b1;
                end
                else
                begin
                    // victim: smallest load or use rank, lowest slot on a tie
                    found = 1'b0;
                    best  = 0;
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (tlb_valid[i] && (!found ||
                            (cfg_lru ? tlb_use[i] < tlb_use[best]
                                     : tlb_load[i] < tlb_load[best])))
                        begin
                            best  = i;
                            found = 1'b1;
                        end
                    end
                    slot     = best;
                    gap_load = tlb_load[slot];
                    gap_use  = tlb_use[slot];
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (tlb_valid[i] && tlb_load[i] > gap_load)
                            tlb_load[i] = tlb_load[i] - 1'b1;
                        if (tlb_valid[i] && tlb_use[i] > gap_use)
                            tlb_use[i] = tlb_use[i] - 1'b1;
                    end
                end
            end
            if (slot >= 0)
            begin
                tlb_valid[slot] = 1'b1;
                tlb_pid[slot]   = c.process_id;
                tlb_page[slot]  = c.page_number;
                tlb_frame[slot] = c.frame_in;
                tlb_load[slot]  = rank_t'(int'(tlb_fill) - 1);
                tlb_use[slot]   = rank_t'(int'(tlb_fill) - 1);
            end
        end
    endtask

    // everything the block does is sampled here, at the rising edge, before
    // the edge's own updates land
    always @(posedge clk)
    begin : monitor
        result_t want;
        result_t pred;
        bit      yields;
        if (rst_n)
        begin
            // a result strobe is taken in the cycle it shows
            if (done)
            begin
                if (pending_lookups.size() == 0)
                begin
                    $error("result with no lookup pending: hit %0d frame_out %h",
                           result.hit, result.frame_out);
                    error_count++;
                end
                else
                begin
                    want = pending_lookups.pop_front();
                    if (result.hit !== want.hit)
                    begin
                        $error("hit: expected %0d, actual %0d", want.hit, result.hit);
                        error_count++;
                    end
                    if (result.frame_out !== want.frame_out)
                    begin
                        $error("frame_out: expected %h, actual %h",
                               want.frame_out, result.frame_out);
                        error_count++;
                    end
                end
            end
            // register writes take effect in the shadow at the same edge
            if (wr_en)
            begin
                if (wr_index == REG_ENTRIES_IN_USE)
                    cfg_entries = wr_data;
                else
                    cfg_lru = wr_data[0];
            end
            // item taken: predict it, a typed-in row overrides the prediction
            if (start && !busy)
            begin
                tlb_predict(cmd, yields, pred);
                if (yields)
                    pending_lookups.push_back(row_typed ? row_want : pred);
            end
            // watchdog on cycles where nothing moves
            if ((start && !busy) || done || wr_en)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // present one item, sometimes after a pause that starts once the block is
    // free again, and wait until it is taken
    task automatic send_item(input cmd_t c, input bit typed, input result_t want);
        if (idle_on && $urandom_range(99) < IDLE_PERCENT)
        begin
            start <= 1'b0;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            repeat ($urandom_range(1, IDLE_MAX)) @(posedge clk);
        end
        start     <= 1'b1;
        cmd       <= c;
        row_typed <= typed;
        row_want  <= want;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // stop sending, let every lookup answer, then let a trailing insert finish
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending_lookups.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // both registers on back-to-back cycles, enable held across them
    task automatic write_regs(input logic [4:0] n, input logic lru);
        wr_en    <= 1'b1;
        wr_index <= REG_ENTRIES_IN_USE;
        wr_data  <= n;
        @(posedge clk);
        wr_index <= REG_REPLACE_LRU;
        wr_data  <= CFG_W'(lru);
        @(posedge clk);
        wr_en    <= 1'b0;
    endtask

    // random item: lookups mostly aim at keys already inserted, inserts
    // sometimes repeat a key to build duplicates
    task automatic make_cmd(output cmd_t c);
        int pick;
        logic [PID_W+PAGE_W-1:0] key;
        c.mode     = ($urandom_range(99) < 45) ? MODE_INSERT : MODE_LOOKUP;
        c.frame_in = FRAME_W'($urandom);
        pick       = $urandom_range(99);
        if (key_pool.size() != 0 && pick < ((c.mode == MODE_LOOKUP) ? 60 : 30))
            key = key_pool[$urandom_range(key_pool.size() - 1)];
        else if (pick < 80)
            key = {PID_W'($urandom_range(3)), PAGE_W'($urandom_range(7))};
        else
            key = {PID_W'($urandom), PAGE_W'($urandom)};
        c.process_id  = key[PID_W+PAGE_W-1:PAGE_W];
        c.page_number = key[PAGE_W-1:0];
        if (c.mode == MODE_INSERT)
        begin
            key_pool.push_back(key);
            if (key_pool.size() > 24)
                void'(key_pool.pop_front());
        end
    endtask

    // script rows
    function automatic row_t look(input logic [PID_W-1:0] pid,
                                  input logic [PAGE_W-1:0] page,
                                  input logic [FRAME_W-1:0] frame);
        row_t r;
        r       = '{ROW_ITEM, '0, 1'b0, '0, '0, 1'b0};
        r.c     = '{MODE_LOOKUP, pid, page, frame};
        return r;
    endfunction

    function automatic row_t look_typed(input logic [PID_W-1:0] pid,
                                        input logic [PAGE_W-1:0] page,
                                        input logic hit,
                                        input logic [FRAME_W-1:0] frame);
        row_t r;
        r       = look(pid, page, '0);
        r.typed = 1'b1;
        r.want  = '{hit, frame};
        return r;
    endfunction

    function automatic row_t ins(input logic [PID_W-1:0] pid,
                                 input logic [PAGE_W-1:0] page,
                                 input logic [FRAME_W-1:0] frame);
        row_t r;
        r       = '{ROW_ITEM, '0, 1'b0, '0, '0, 1'b0};
        r.c     = '{MODE_INSERT, pid, page, frame};
        return r;
    endfunction

    function automatic row_t cfg(input logic [4:0] n, input logic lru);
        row_t r;
        r       = '{ROW_CONFIG, '0, 1'b0, '0, n, lru};
        return r;
    endfunction

    initial
    begin : stimulus
        row_t        script [$];
        cmd_t        c;
        // random phases: entry count, victim choice, item count
        logic [4:0]  phase_n     [10] = '{5'd16, 5'd16, 5'd1, 5'd1, 5'd31,
                                          5'd0, 5'd5, 5'd3, 5'd2, 5'd16};
        logic        phase_lru   [10] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1,
                                          1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        int          phase_items [10] = '{80, 80, 60, 60, 80, 20, 80, 70, 60, 60};

        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        wr_en       = 1'b0;
        wr_index    = REG_ENTRIES_IN_USE;
        wr_data     = '0;
        row_typed   = 1'b0;
        row_want    = '0;
        error_count = 0;
        quiet_cycles = 0;
        idle_on     = 1'b1;
        tlb_clear();

        // empty buffer misses at both ends of the key space
        script.push_back(look_typed(16'h0000, 20'h00000, 1'b0, 20'h00000));
        script.push_back(look_typed(16'hFFFF, 20'hFFFFF, 1'b0, 20'h00000));
        script.push_back(ins(16'h0000, 20'h00000, 20'hFFFFF));
        script.push_back(ins(16'hFFFF, 20'hFFFFF, 20'h00000));
        script.push_back(look_typed(16'h0000, 20'h00000, 1'b1, 20'hFFFFF));
        script.push_back(look_typed(16'hFFFF, 20'hFFFFF, 1'b1, 20'h00000));
        // duplicate key: the older load still answers
        script.push_back(ins(16'h0000, 20'h00000, 20'h12345));
        script.push_back(look_typed(16'h0000, 20'h00000, 1'b1, 20'hFFFFF));
        // frame_in is ignored on a lookup, near misses on the page and on the process id
        script.push_back(look(16'h0000, 20'h00001, 20'hFFFFF));
        script.push_back(look(16'h0001, 20'h00000, 20'hFFFFF));
        // zero entries: the insert is dropped
        script.push_back(cfg(5'd0, 1'b0));
        script.push_back(ins(16'h0001, 20'h00001, 20'h00001));
        script.push_back(look_typed(16'h0001, 20'h00001, 1'b0, 20'h00000));
        // count below fill: replace among all valid slots, oldest load first
        script.push_back(cfg(5'd2, 1'b0));
        script.push_back(ins(16'h0002, 20'h00002, 20'h00002));
        script.push_back(look(16'h0000, 20'h00000, 20'h00000));
        script.push_back(look(16'h0002, 20'h00002, 20'h00000));
        // least recently used victim after a lookup refreshes one entry
        script.push_back(cfg(5'd2, 1'b1));
        script.push_back(look(16'hFFFF, 20'hFFFFF, 20'h00000));
        script.push_back(ins(16'h0003, 20'h00003, 20'h00003));
        script.push_back(look(16'h0002, 20'h00002, 20'h00000));
        script.push_back(look(16'h0003, 20'h00003, 20'h00000));
        // count above the buffer size acts as the full buffer
        script.push_back(cfg(5'd31, 1'b0));
        script.push_back(ins(16'hA5A5, 20'h5A5A5, 20'hABCDE));
        script.push_back(look(16'hA5A5, 20'h5A5A5, 20'h00000));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed script
        foreach (script[i])
        begin
            if (script[i].kind == ROW_CONFIG)
            begin
                settle();
                write_regs(script[i].n, script[i].lru);
            end
            else
                send_item(script[i].c, script[i].typed, script[i].want);
        end

        // random phases, each behind a full drain and a register write
        for (int p = 0; p < 10; p++)
        begin
            settle();
            write_regs(phase_n[p], phase_lru[p]);
            // one long stretch with the sender never pausing
            idle_on = (p != 1);
            for (int k = 0; k < phase_items[p]; k++)
            begin
                make_cmd(c);
                send_item(c, 1'b0, '0);
            end
        end

        settle();
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
